// ===== design/lsap_pkg.sv =====
// lsap_pkg: shared widths, constants and types for the line sensor
// average and pulse width block. No dependencies.

package lsap_pkg;

    localparam int WINDOW_LEN  = 10;
    localparam int SAMPLE_W    = 12;
    localparam int TIME_W      = 64;
    localparam int WIN_IDX_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOTAL_W     = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(WINDOW_LEN) + 2;
    localparam int PROD_W      = TOTAL_W + RECIP_W;

    // ceil(2^RECIP_SHIFT / WINDOW_LEN): exact truncating divide for any total
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(1500);

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BLACK = 2'd1,
        EV_WHITE = 2'd2
    } t_color_event;

    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TIME_W-1:0]  now_us;
    } t_win_beat;

endpackage

// ===== design/lsap_cell.sv =====
// lsap_cell: one sample slot of the window shift chain.
// Depends on lsap_pkg.

module lsap_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsap_pkg::t_cell_ctl           i_ctl,
    input  logic [lsap_pkg::SAMPLE_W-1:0] i_d,
    output logic [lsap_pkg::SAMPLE_W-1:0] o_q
);

    logic [lsap_pkg::SAMPLE_W-1:0] r_q;
    logic [lsap_pkg::SAMPLE_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.load) begin
            n_q = i_ctl.clear ? '0 : i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/lsap_timer.sv =====
// lsap_timer: divides the window total, classes the average and times
// colour pulses; holds the output register. Depends on lsap_pkg.

module lsap_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lsap_pkg::SAMPLE_W-1:0] i_thresh,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lsap_pkg::t_win_beat           i_beat,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lsap_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                          o_on_line,
    output lsap_pkg::t_color_event        o_color_event,
    output logic                          o_width_valid,
    output logic                          o_width_was_black,
    output logic [lsap_pkg::TIME_W-1:0]   o_width_us
);

    logic                          r_valid;
    logic [lsap_pkg::SAMPLE_W-1:0] r_filtered;
    logic                          r_on_line;
    lsap_pkg::t_color_event        r_event;
    logic                          r_width_valid;
    logic                          r_width_was_black;
    logic [lsap_pkg::TIME_W-1:0]   r_width_us;
    logic                          r_timing_black;
    logic                          r_timing_white;
    logic [lsap_pkg::TIME_W-1:0]   r_black_start;
    logic [lsap_pkg::TIME_W-1:0]   r_white_start;

    logic                          n_valid;
    logic                          n_timing_black;
    logic                          n_timing_white;
    logic [lsap_pkg::TIME_W-1:0]   n_black_start;
    logic [lsap_pkg::TIME_W-1:0]   n_white_start;
    lsap_pkg::t_color_event        n_event;
    logic                          n_width_valid;
    logic                          n_width_was_black;
    logic [lsap_pkg::TIME_W-1:0]   n_width_us;

    logic                          load;
    logic [lsap_pkg::PROD_W-1:0]   prod;
    logic [lsap_pkg::SAMPLE_W-1:0] filt;
    logic                          blk;
    logic [lsap_pkg::TIME_W-1:0]   black_len;
    logic [lsap_pkg::TIME_W-1:0]   white_len;

    assign o_in_ready = !r_valid || !i_stall;
    assign load       = i_in_valid && o_in_ready;

    // total / WINDOW_LEN by reciprocal multiply
    assign prod = {{lsap_pkg::RECIP_W{1'b0}}, i_beat.total}
                * {{lsap_pkg::TOTAL_W{1'b0}}, lsap_pkg::RECIP};
    assign filt = prod[lsap_pkg::RECIP_SHIFT +: lsap_pkg::SAMPLE_W];
    assign blk  = filt > i_thresh;

    assign black_len = i_beat.now_us - r_black_start;
    assign white_len = i_beat.now_us - r_white_start;

    always_comb begin
        n_valid           = r_valid && i_stall;
        n_timing_black    = r_timing_black;
        n_timing_white    = r_timing_white;
        n_black_start     = r_black_start;
        n_white_start     = r_white_start;
        n_event           = lsap_pkg::EV_NONE;
        n_width_valid     = 1'b0;
        n_width_was_black = 1'b0;
        n_width_us        = '0;
        if (load) begin
            n_valid = 1'b1;
            if (blk) begin
                if (!r_timing_black) begin
                    n_black_start  = i_beat.now_us;
                    n_timing_black = 1'b1;
                    n_event        = lsap_pkg::EV_BLACK;
                end
                if (r_timing_white) begin
                    n_width_us     = white_len;
                    n_width_valid  = 1'b1;
                    n_timing_white = 1'b0;
                end
            end else begin
                if (r_timing_black) begin
                    n_width_us        = black_len;
                    n_width_valid     = 1'b1;
                    n_width_was_black = 1'b1;
                    n_timing_black    = 1'b0;
                end
                if (!r_timing_white) begin
                    n_white_start  = i_beat.now_us;
                    n_timing_white = 1'b1;
                    n_event        = lsap_pkg::EV_WHITE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_timing_black <= 1'b0;
            r_timing_white <= 1'b0;
            r_black_start  <= '0;
            r_white_start  <= '0;
        end else begin
            r_valid        <= n_valid;
            r_timing_black <= n_timing_black;
            r_timing_white <= n_timing_white;
            r_black_start  <= n_black_start;
            r_white_start  <= n_white_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_filtered        <= filt;
            r_on_line         <= blk;
            r_event           <= n_event;
            r_width_valid     <= n_width_valid;
            r_width_was_black <= n_width_was_black;
            r_width_us        <= n_width_us;
        end
    end

    assign o_valid           = r_valid;
    assign o_filtered        = r_filtered;
    assign o_on_line         = r_on_line;
    assign o_color_event     = r_event;
    assign o_width_valid     = r_width_valid;
    assign o_width_was_black = r_width_was_black;
    assign o_width_us        = r_width_us;

    a_one_colour_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_timing_black && r_timing_white))
        else $error("both colours timed at once");

    a_black_no_white_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_on_line) |-> (r_event != lsap_pkg::EV_WHITE))
        else $error("white start on a black average");

endmodule

// ===== design/line_sensor_average_and_pulse_width_top.sv =====
// line_sensor_average_and_pulse_width_top: window shift chain of lsap_cell
// with running total, feeding lsap_timer. Depends on lsap_pkg, lsap_cell,
// lsap_timer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  config   | i_cfg_we           | i_cfg_data (black threshold)
//  input    | i_valid / o_stall  | i_sample, i_now_us
//  output   | o_valid / i_stall  | o_filtered, o_on_line, o_color_event,
//           |                    | o_width_valid, o_width_was_black, o_width_us
//
// One beat per cycle sustained while i_stall is low; window update stage,
// then divide, class and timing stage into the output register.
// Synchronous active-low reset clears the window cells, total, timing state
// and sets the threshold to 1500.
// A stalled output holds; the window stage keeps taking beats until it too
// holds one.

module line_sensor_average_and_pulse_width_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsap_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lsap_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [lsap_pkg::TIME_W-1:0]   i_now_us,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lsap_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                          o_on_line,
    output logic [1:0]                    o_color_event,
    output logic                          o_width_valid,
    output logic                          o_width_was_black,
    output logic [lsap_pkg::TIME_W-1:0]   o_width_us
);

    localparam int N = lsap_pkg::WINDOW_LEN;

    logic [lsap_pkg::SAMPLE_W-1:0] r_thresh;
    logic                          r_last_raw_black;
    logic [lsap_pkg::TOTAL_W-1:0]  r_total;
    logic                          r_s1_valid;
    logic [lsap_pkg::TIME_W-1:0]   r_s1_now;

    logic [lsap_pkg::SAMPLE_W-1:0] n_thresh;
    logic                          n_last_raw_black;
    logic [lsap_pkg::TOTAL_W-1:0]  n_total;
    logic                          n_s1_valid;

    logic                          in_ready;
    logic                          accept;
    logic                          s2_ready;
    logic                          raw_black;
    logic                          clear;
    logic [lsap_pkg::TOTAL_W-1:0]  base;
    logic [lsap_pkg::TOTAL_W-1:0]  drop;
    lsap_pkg::t_cell_ctl           head_ctl;
    lsap_pkg::t_cell_ctl           body_ctl;
    lsap_pkg::t_win_beat           s1_beat;
    lsap_pkg::t_color_event        color_event;

    logic [lsap_pkg::SAMPLE_W-1:0] cell_q [N];

    assign in_ready = !r_s1_valid || s2_ready;
    assign o_stall  = !in_ready;
    assign accept   = i_valid && in_ready;

    assign raw_black = i_sample > r_thresh;
    assign clear     = raw_black != r_last_raw_black;
    assign base      = clear ? '0 : r_total;
    assign drop      = clear ? '0 : {{(lsap_pkg::TOTAL_W-lsap_pkg::SAMPLE_W){1'b0}}, cell_q[N-1]};

    assign head_ctl = '{load: accept, clear: 1'b0};
    assign body_ctl = '{load: accept, clear: clear};

    lsap_cell u_cell_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (head_ctl),
        .i_d     (i_sample),
        .o_q     (cell_q[0])
    );

    for (genvar k = 1; k < N; k++) begin : g_cell
        lsap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (body_ctl),
            .i_d     (cell_q[k-1]),
            .o_q     (cell_q[k])
        );
    end

    always_comb begin
        n_thresh         = i_cfg_we ? i_cfg_data : r_thresh;
        n_last_raw_black = r_last_raw_black;
        n_total          = r_total;
        n_s1_valid       = r_s1_valid && !s2_ready;
        if (accept) begin
            n_last_raw_black = raw_black;
            n_total          = base - drop
                             + {{(lsap_pkg::TOTAL_W-lsap_pkg::SAMPLE_W){1'b0}}, i_sample};
            n_s1_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh         <= lsap_pkg::THRESH_RESET;
            r_last_raw_black <= 1'b0;
            r_total          <= '0;
            r_s1_valid       <= 1'b0;
        end else begin
            r_thresh         <= n_thresh;
            r_last_raw_black <= n_last_raw_black;
            r_total          <= n_total;
            r_s1_valid       <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_now <= i_now_us;
        end
    end

    assign s1_beat = '{total: r_total, now_us: r_s1_now};

    lsap_timer u_timer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_thresh          (r_thresh),
        .i_in_valid        (r_s1_valid),
        .o_in_ready        (s2_ready),
        .i_beat            (s1_beat),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_filtered        (o_filtered),
        .o_on_line         (o_on_line),
        .o_color_event     (color_event),
        .o_width_valid     (o_width_valid),
        .o_width_was_black (o_width_was_black),
        .o_width_us        (o_width_us)
    );

    assign o_color_event = color_event;

    a_width_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_width_valid) |-> (color_event != lsap_pkg::EV_NONE))
        else $error("width reported without a colour change");

    a_no_width_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_width_valid) |-> (o_width_us == '0 && !o_width_was_black))
        else $error("width fields not cleared");

    a_held_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> $stable(r_total))
        else $error("window total moved while its beat was held");

endmodule

// ===== tb/line_sensor_average_and_pulse_width_top_test.sv =====
// Self-checking test of line_sensor_average_and_pulse_width_top: directed table, then
// random colour runs under random gaps and stalls, checked against an in-bench predictor.
// Depends on lsap_pkg and the block's RTL.
`timescale 1ns / 1ps

module line_sensor_average_and_pulse_width_top_test;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_BEATS = 480;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [lsap_pkg::SAMPLE_W-1:0] filtered;
        logic                          on_line;
        logic [1:0]                    color_event;
        logic                          width_valid;
        logic                          width_was_black;
        logic [lsap_pkg::TIME_W-1:0]   width_us;
    } t_sensor_result;

    typedef struct packed {
        logic                          set_threshold;
        logic [lsap_pkg::SAMPLE_W-1:0] value;
        logic [lsap_pkg::TIME_W-1:0]   stamp;
        logic                          pinned;
        t_sensor_result                result;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [lsap_pkg::SAMPLE_W-1:0] i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [lsap_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic [lsap_pkg::TIME_W-1:0]   i_now_us = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [lsap_pkg::SAMPLE_W-1:0] o_filtered;
    logic                          o_on_line;
    logic [1:0]                    o_color_event;
    logic                          o_width_valid;
    logic                          o_width_was_black;
    logic [lsap_pkg::TIME_W-1:0]   o_width_us;

    line_sensor_average_and_pulse_width_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .i_now_us          (i_now_us),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_filtered        (o_filtered),
        .o_on_line         (o_on_line),
        .o_color_event     (o_color_event),
        .o_width_valid     (o_width_valid),
        .o_width_was_black (o_width_was_black),
        .o_width_us        (o_width_us)
    );

    // predictor state
    logic [lsap_pkg::SAMPLE_W-1:0] threshold_m = lsap_pkg::THRESH_RESET;
    logic [lsap_pkg::SAMPLE_W-1:0] window_m [lsap_pkg::WINDOW_LEN];
    logic [15:0]                   total_m = '0;
    int                            slot_m = 0;
    logic                          last_raw_black_m = 1'b0;
    logic                          timing_black_m = 1'b0;
    logic                          timing_white_m = 1'b0;
    logic [lsap_pkg::TIME_W-1:0]   black_start_m = '0;
    logic [lsap_pkg::TIME_W-1:0]   white_start_m = '0;

    t_sensor_result pending_readings [$];
    bit             pin_flags [$];
    t_sensor_result pin_results [$];
    int             mismatches = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             quiet_mode = 1'b0;
    t_stim_row      directed_rows [26];

    initial begin
        foreach (window_m[k]) window_m[k] = '0;
    end

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_sensor_result filter_and_time(
            input logic [lsap_pkg::SAMPLE_W-1:0] s,
            input logic [lsap_pkg::TIME_W-1:0] t);
        t_sensor_result r;
        logic           raw_black;
        r = '0;
        raw_black = s > threshold_m;
        if (raw_black != last_raw_black_m) begin
            foreach (window_m[k]) window_m[k] = '0;
            total_m = '0;
            slot_m = 0;
            last_raw_black_m = raw_black;
        end
        total_m = total_m - window_m[slot_m] + s;
        window_m[slot_m] = s;
        slot_m = (slot_m == lsap_pkg::WINDOW_LEN - 1) ? 0 : slot_m + 1;
        r.filtered = lsap_pkg::SAMPLE_W'(total_m / lsap_pkg::WINDOW_LEN);
        r.on_line = r.filtered > threshold_m;
        r.color_event = lsap_pkg::EV_NONE;
        if (r.on_line) begin
            if (!timing_black_m) begin
                black_start_m = t;
                timing_black_m = 1'b1;
                r.color_event = lsap_pkg::EV_BLACK;
            end
            if (timing_white_m) begin
                r.width_us = t - white_start_m;
                r.width_valid = 1'b1;
                r.width_was_black = 1'b0;
                timing_white_m = 1'b0;
            end
        end else begin
            if (timing_black_m) begin
                r.width_us = t - black_start_m;
                r.width_valid = 1'b1;
                r.width_was_black = 1'b1;
                timing_black_m = 1'b0;
            end
            if (!timing_white_m) begin
                white_start_m = t;
                timing_white_m = 1'b1;
                r.color_event = lsap_pkg::EV_WHITE;
            end
        end
        return r;
    endfunction

    function automatic bit field_matches(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %h, actual %h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_sensor_result make_result(
            input logic [lsap_pkg::SAMPLE_W-1:0] filt,
            input logic blk, input logic [1:0] ev,
            input logic wv, input logic wb,
            input logic [lsap_pkg::TIME_W-1:0] wus);
        t_sensor_result r;
        r = {filt, blk, ev, wv, wb, wus};
        return r;
    endfunction

    function automatic t_stim_row sample_row(input logic [lsap_pkg::SAMPLE_W-1:0] s,
                                             input logic [lsap_pkg::TIME_W-1:0] t);
        t_stim_row row;
        row = '0;
        row.value = s;
        row.stamp = t;
        return row;
    endfunction

    function automatic t_stim_row check_row(input logic [lsap_pkg::SAMPLE_W-1:0] s,
                                            input logic [lsap_pkg::TIME_W-1:0] t,
                                            input t_sensor_result r);
        t_stim_row row;
        row = sample_row(s, t);
        row.pinned = 1'b1;
        row.result = r;
        return row;
    endfunction

    function automatic t_stim_row threshold_row(input logic [lsap_pkg::SAMPLE_W-1:0] v);
        t_stim_row row;
        row = '0;
        row.set_threshold = 1'b1;
        row.value = v;
        return row;
    endfunction

    // input acceptance and output checking
    always @(posedge i_clk) begin : monitor
        t_sensor_result want;
        t_sensor_result got;
        bit             pin;
        t_sensor_result pin_res;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = filter_and_time(i_sample, i_now_us);
                pin = pin_flags.pop_front();
                pin_res = pin_results.pop_front();
                pending_readings.push_back(pin ? pin_res : want);
            end
            if (o_valid && !i_stall) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t unexpected beat: expected none, actual filtered %h",
                             $time, o_filtered);
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    got = {o_filtered, o_on_line, o_color_event, o_width_valid,
                           o_width_was_black, o_width_us};
                    if (!(field_matches("filtered", want.filtered, got.filtered)
                          & field_matches("on_line", want.on_line, got.on_line)
                          & field_matches("color_event", want.color_event, got.color_event)
                          & field_matches("width_valid", want.width_valid, got.width_valid)
                          & field_matches("width_was_black", want.width_was_black,
                                          got.width_was_black)
                          & field_matches("width_us", want.width_us, got.width_us)))
                        mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : stall_gen
        int pick;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (quiet_mode) begin
            i_stall <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                stall_left <= $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else if (pick < 23) begin
                stall_left <= $urandom_range(10, 40);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic [lsap_pkg::SAMPLE_W-1:0] s,
                             input logic [lsap_pkg::TIME_W-1:0] t,
                             input bit pin, input t_sensor_result r);
        pin_flags.push_back(pin);
        pin_results.push_back(r);
        i_valid <= 1'b1;
        i_sample <= s;
        i_now_us <= t;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_gap();
        int gap;
        int pick;
        gap = 0;
        if (!quiet_mode) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)
                gap = $urandom_range(10, 40);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // only while idle: drain every expected beat first
    task automatic write_threshold(input logic [lsap_pkg::SAMPLE_W-1:0] v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold_m = v;
    endtask

    initial begin : stimulus
        logic [lsap_pkg::SAMPLE_W-1:0] s;
        logic [lsap_pkg::TIME_W-1:0]   stamp_now;
        int                            sent;
        int                            pick;
        int                            thr;
        int                            phase_len;
        int                            run_left;
        bit                            run_black;

        directed_rows = '{
            check_row(12'd0, 64'd100,
                      make_result(12'd0, 1'b0, lsap_pkg::EV_WHITE, 1'b0, 1'b0, 64'd0)),
            sample_row(12'd4095, 64'd200),
            sample_row(12'd4095, 64'd300),
            sample_row(12'd4095, 64'd400),
            sample_row(12'd4095, 64'd500),
            sample_row(12'd4095, 64'd600),
            sample_row(12'd4095, 64'd700),
            sample_row(12'd4095, 64'd800),
            sample_row(12'd4095, 64'd900),
            sample_row(12'd4095, 64'd1000),
            check_row(12'd4095, 64'd1100,
                      make_result(12'd4095, 1'b1, lsap_pkg::EV_NONE, 1'b0, 1'b0, 64'd0)),
            check_row(12'd0, 64'd1300,
                      make_result(12'd0, 1'b0, lsap_pkg::EV_WHITE, 1'b1, 1'b1, 64'd800)),
            sample_row(12'd1500, 64'd1400),
            sample_row(12'd1501, 64'hFFFF_FFFF_FFFF_FFFF),
            threshold_row(12'd0),
            sample_row(12'd0, 64'd5),
            sample_row(12'd4095, 64'hFFFF_FFFF_FFFF_FF00),
            sample_row(12'd1, 64'h10),
            // black width wraps past 2^64
            check_row(12'd0, 64'h20,
                      make_result(12'd0, 1'b0, lsap_pkg::EV_WHITE, 1'b1, 1'b1, 64'h120)),
            threshold_row(12'd4095),
            sample_row(12'd4095, 64'h30),
            sample_row(12'hAAA, 64'h5555_5555_5555_5555),
            sample_row(12'h555, 64'hAAAA_AAAA_AAAA_AAAA),
            threshold_row(12'h800),
            sample_row(12'h801, 64'hAAAA_AAAA_AAAA_AAAB),
            sample_row(12'h800, 64'hAAAA_AAAA_AAAA_AAAC)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].set_threshold) begin
                write_threshold(directed_rows[k].value);
            end else begin
                send_beat(directed_rows[k].value, directed_rows[k].stamp,
                          directed_rows[k].pinned, directed_rows[k].result);
                idle_gap();
            end
        end

        // random colour runs, with some noise samples and time jumps
        sent = 0;
        run_left = 0;
        run_black = 1'b0;
        stamp_now = {$urandom, $urandom};
        while (sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 5);
                write_threshold(pick == 0 ? 12'd0 : pick == 1 ? 12'd4095 :
                                pick == 2 ? lsap_pkg::THRESH_RESET :
                                lsap_pkg::SAMPLE_W'($urandom));
            end
            quiet_mode = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 60);
            thr = threshold_m;
            repeat (phase_len) begin
                if (run_left == 0) begin
                    run_black = $urandom_range(0, 1);
                    run_left = $urandom_range(1, 25);
                end
                run_left--;
                pick = $urandom_range(0, 99);
                if (pick < 10 || (run_black && thr == 4095))
                    s = lsap_pkg::SAMPLE_W'($urandom);
                else if (run_black)
                    s = lsap_pkg::SAMPLE_W'($urandom_range(4095, thr + 1));
                else
                    s = lsap_pkg::SAMPLE_W'($urandom_range(thr, 0));
                if ($urandom_range(0, 99) < 3)
                    stamp_now = {$urandom, $urandom};
                else
                    stamp_now = stamp_now + $urandom_range(1, 3000);
                send_beat(s, stamp_now, 1'b0, '0);
                idle_gap();
                sent++;
            end
        end

        i_valid <= 1'b0;
        quiet_mode = 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lsap_pkg.sv
design/lsap_cell.sv
design/lsap_timer.sv
design/line_sensor_average_and_pulse_width_top.sv
tb/line_sensor_average_and_pulse_width_top_test.sv
